@@ rtl/core/ste_pkg.sv @@
// Shared types, constants and codes of the sorted table engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int FUNC_W      = 3;
    localparam int STAT_W      = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOCATE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RETRIEVE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REVERSE  = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef logic signed [VALUE_WIDTH-1:0] word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_LAST,
        S_INS_FIRST,
        S_INS_SCAN,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_LOC_SCAN,
        S_RET_READ,
        S_REV_B,
        S_REV_C,
        S_REV_D,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        word_t            data;
    } ram_wr_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

endpackage

`default_nettype wire

@@ rtl/core/sorted_table_engine_unit.sv @@
// Top level of the sorted table engine: sequencer, table count and result registers.
// Depends on ste_pkg, ste_ram and ste_cmp.
//
//   channel   ports                                         handshake
//   -------   -------------------------------------------   -------------------------
//   request   func, value, position                         start high while busy low
//   result    status, found_position, read_value,           done high for one cycle
//             entry_count
//
// A request walks the table one entry per cycle through the single read port of the
// entry RAM and the shared compare unit. busy stays high from acceptance until the
// cycle after done. Reset clears the count, the sequencer and the read-valid flag
// only; entry contents stay undefined until written and need no clearing pass.
// done is high for exactly one cycle and cannot be held off; the result fields
// then hold until the next request is accepted.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_engine_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ste_pkg::FUNC_W-1:0]    func,
    input  wire ste_pkg::word_t                value,
    input  wire logic [ste_pkg::CNT_W-1:0]     position,
    output logic                               done,
    output logic [ste_pkg::STAT_W-1:0]         status,
    output logic [ste_pkg::CNT_W-1:0]          found_position,
    output ste_pkg::word_t                     read_value,
    output logic [ste_pkg::CNT_W-1:0]          entry_count
);
    import ste_pkg::*;

    // Control state
    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                rvalid_reg;

    // Work registers
    logic [IDX_W-1:0]    tag_reg;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic [CNT_W-1:0]    mark_reg,   mark_next;
    word_t               val_reg,    val_next;
    word_t               tmp_reg,    tmp_next;

    // Result registers
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [CNT_W-1:0]    found_reg,  found_next;
    word_t               rdval_reg,  rdval_next;

    // RAM and compare unit
    ram_wr_t             wr;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    word_t               rd_data;
    cmp_res_t            cmp;

    // Shared conditions
    logic                in_range;
    logic                scan_stop;
    logic                loc_hit;
    logic                walk_open;
    logic                shift_hit;
    logic                rev_more;

    ste_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ste_cmp u_cmp (
        .key   (val_reg),
        .entry (rd_data),
        .res   (cmp)
    );

    assign in_range  = (position != '0) && (position <= count_reg);
    // Insert point: first entry the key is not greater than
    assign scan_stop = rvalid_reg && !cmp.gt;
    assign loc_hit   = rvalid_reg && cmp.eq;
    assign walk_open = (idx_reg < count_reg);
    assign shift_hit = rvalid_reg && (tag_reg == mark_reg[IDX_W-1:0]);
    assign rev_more  = ((idx_reg + 1'b1) < (mark_reg - 1'b1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FN_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                state_next = S_DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                state_next = S_INS_LAST;
                            end
                        end
                        FN_DELETE:   state_next = in_range ? S_DEL_SHIFT : S_DONE;
                        FN_LOCATE:   state_next = S_LOC_SCAN;
                        FN_RETRIEVE: state_next = in_range ? S_RET_READ : S_DONE;
                        FN_REVERSE:  state_next = (count_reg > CNT_W'(1)) ? S_REV_B : S_DONE;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_INS_LAST:  state_next = cmp.gt ? S_INS_FIRST : S_INS_SCAN;
            S_INS_FIRST: state_next = (cmp.gt || cmp.eq) ? S_INS_PUT : S_INS_SHIFT;
            S_INS_SCAN:  state_next = scan_stop ? S_INS_SHIFT : S_INS_SCAN;
            S_INS_SHIFT: state_next = shift_hit ? S_INS_PUT : S_INS_SHIFT;
            S_INS_PUT:   state_next = S_DONE;
            S_DEL_SHIFT:
            begin
                if (!walk_open && !rvalid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_LOC_SCAN:
            begin
                if (loc_hit || (!walk_open && !rvalid_reg))
                begin
                    state_next = S_DONE;
                end
            end
            S_RET_READ:  state_next = S_DONE;
            S_REV_B:     state_next = S_REV_C;
            S_REV_C:     state_next = S_REV_D;
            S_REV_D:     state_next = rev_more ? S_REV_B : S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = idx_reg[IDX_W-1:0];
        wr          = '0;
        count_next  = count_reg;
        idx_next    = idx_reg;
        mark_next   = mark_reg;
        val_next    = val_reg;
        tmp_next    = tmp_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rdval_next  = rdval_reg;
        done        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Capture the request and clear the result fields
                    val_next    = value;
                    status_next = ST_OK;
                    found_next  = '0;
                    rdval_next  = '0;
                    case (func)
                        FN_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                mark_next = '0;
                            end
                            else
                            begin
                                // Fetch the last entry first
                                rd_en   = 1'b1;
                                rd_addr = IDX_W'(count_reg - 1'b1);
                            end
                        end
                        FN_DELETE:
                        begin
                            if (!in_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next = position;
                            end
                        end
                        FN_LOCATE:
                        begin
                            idx_next = '0;
                        end
                        FN_RETRIEVE:
                        begin
                            if (!in_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = IDX_W'(position - 1'b1);
                            end
                        end
                        FN_REVERSE:
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                rd_en     = 1'b1;
                                rd_addr   = '0;
                                idx_next  = '0;
                                mark_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_INS_LAST:
            begin
                if (cmp.gt)
                begin
                    // Past the last entry: the front still wins if the key is below it
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
                else
                begin
                    idx_next = '0;
                end
            end
            S_INS_FIRST:
            begin
                if (cmp.gt || cmp.eq)
                begin
                    mark_next = count_reg;
                end
                else
                begin
                    // Below the first entry: shift the whole table up
                    mark_next = '0;
                    idx_next  = count_reg - 1'b1;
                end
            end
            S_INS_SCAN:
            begin
                if (walk_open && !scan_stop)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (scan_stop)
                begin
                    mark_next = CNT_W'(tag_reg);
                    idx_next  = count_reg - 1'b1;
                end
            end
            S_INS_SHIFT:
            begin
                // Move entries up one place, top first
                if (idx_reg >= mark_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
                if (rvalid_reg)
                begin
                    wr.en   = 1'b1;
                    wr.addr = tag_reg + 1'b1;
                    wr.data = rd_data;
                end
            end
            S_INS_PUT:
            begin
                wr.en      = 1'b1;
                wr.addr    = mark_reg[IDX_W-1:0];
                wr.data    = val_reg;
                count_next = count_reg + 1'b1;
            end
            S_DEL_SHIFT:
            begin
                // Move entries down one place over the deleted slot
                if (walk_open)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rvalid_reg)
                begin
                    wr.en   = 1'b1;
                    wr.addr = tag_reg - 1'b1;
                    wr.data = rd_data;
                end
                if (!walk_open && !rvalid_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            S_LOC_SCAN:
            begin
                if (walk_open && !loc_hit)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (loc_hit)
                begin
                    found_next = CNT_W'(tag_reg) + 1'b1;
                end
                else if (!walk_open && !rvalid_reg)
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            S_RET_READ:
            begin
                rdval_next = rd_data;
            end
            S_REV_B:
            begin
                // Hold the low entry, fetch the high one
                tmp_next = rd_data;
                rd_en    = 1'b1;
                rd_addr  = mark_reg[IDX_W-1:0];
            end
            S_REV_C:
            begin
                wr.en   = 1'b1;
                wr.addr = idx_reg[IDX_W-1:0];
                wr.data = rd_data;
            end
            S_REV_D:
            begin
                wr.en     = 1'b1;
                wr.addr   = mark_reg[IDX_W-1:0];
                wr.data   = tmp_reg;
                idx_next  = idx_reg + 1'b1;
                mark_next = mark_reg - 1'b1;
                if (rev_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(idx_reg + 1'b1);
                end
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg    <= rd_addr;
        idx_reg    <= idx_next;
        mark_reg   <= mark_next;
        val_reg    <= val_next;
        tmp_reg    <= tmp_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rdval_reg  <= rdval_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign status         = status_reg;
    assign found_position = found_reg;
    assign read_value     = rdval_reg;
    assign entry_count    = count_reg;

endmodule

`default_nettype wire

@@ rtl/core/ste_ram.sv @@
// Entry storage of the sorted table: one write port, one registered read port.
// Depends on ste_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ste_ram (
    input  wire logic                     clk,
    input  wire ste_pkg::ram_wr_t         wr,
    input  wire logic                     rd_en,
    input  wire logic [ste_pkg::IDX_W-1:0] rd_addr,
    output ste_pkg::word_t                rd_data
);
    import ste_pkg::*;

    word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ste_cmp.sv @@
// Shared signed compare unit: request key against the entry just read.
// Depends on ste_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ste_cmp (
    input  wire ste_pkg::word_t    key,
    input  wire ste_pkg::word_t    entry,
    output ste_pkg::cmp_res_t      res
);
    import ste_pkg::*;

    always_comb
    begin
        res.gt = (key > entry);
        res.eq = (key == entry);
    end

endmodule

`default_nettype wire
